### hw/rtl/sir_pkg.sv
package sir_pkg;

  localparam int MaxSeqs    = 64;
  localparam int MaxCols    = 512;
  localparam int StoreDepth = MaxSeqs * MaxCols;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int SeqW       = $clog2(MaxSeqs + 1);
  localparam int IdxW       = $clog2(MaxSeqs);
  localparam int ColW       = $clog2(MaxCols + 1);

  localparam int ResW     = 8;
  localparam int NumSeqsW = 7;
  localparam int NumColsW = 10;
  localparam int ThrW     = 9;
  localparam int CfgW     = 10;
  localparam int CfgIdxW  = 2;
  localparam int OutIdxW  = 6;
  localparam int SizeW    = 7;
  localparam int WeightW  = 16;
  localparam int OutDataW = 32;
  localparam int CmpW     = (ColW > ThrW) ? ColW : ThrW;

  localparam logic [CfgIdxW-1:0] RegNumSeqs = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumCols = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThresh  = 2'd2;

  localparam logic [NumSeqsW-1:0] NumSeqsRst = 7'd64;
  localparam logic [NumColsW-1:0] NumColsRst = 10'd512;
  localparam logic [ThrW-1:0]     ThreshRst  = 9'd409;

  // floor(32768 / size), indexed by size - 1
  localparam logic [WeightW-1:0] WeightLut [64] = '{
    16'd32768, 16'd16384, 16'd10922, 16'd8192, 16'd6553, 16'd5461, 16'd4681, 16'd4096,
    16'd3640,  16'd3276,  16'd2978,  16'd2730, 16'd2520, 16'd2340, 16'd2184, 16'd2048,
    16'd1927,  16'd1820,  16'd1724,  16'd1638, 16'd1560, 16'd1489, 16'd1424, 16'd1365,
    16'd1310,  16'd1260,  16'd1213,  16'd1170, 16'd1129, 16'd1092, 16'd1057, 16'd1024,
    16'd992,   16'd963,   16'd936,   16'd910,  16'd885,  16'd862,  16'd840,  16'd819,
    16'd799,   16'd780,   16'd762,   16'd744,  16'd728,  16'd712,  16'd697,  16'd682,
    16'd668,   16'd655,   16'd642,   16'd630,  16'd618,  16'd606,  16'd595,  16'd585,
    16'd574,   16'd564,   16'd555,   16'd546,  16'd537,  16'd528,  16'd520,  16'd512
  };

endpackage

### hw/rtl/sir_ram.sv
module sir_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### hw/rtl/sequence_identity_reweight.sv
// channel   dir  payload (low bit up)                              end marker
// s_axis    in   tdata: residue[7:0]                               -
// m_axis    out  tdata: seq_index[5:0] cluster_size[12:6]          tlast
//                       weight_q15[28:13] zero[31:29]
// cfg       in   cfg_idx_i selects num_seqs / num_cols / threshold  -
//
// Load: one residue per cycle, s_axis_tready high throughout.
// Compare: one column pair per cycle from the dual-read residue store, with the
//   input held off.
// Reset clears control and loads config defaults only; the residue store is written before read.
// A held result stalls the sequencer only when the next result is due.
module sequence_identity_reweight (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sir_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sir_pkg::ResW-1:0]      s_axis_tdata,   // residue
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sir_pkg::OutDataW-1:0]  m_axis_tdata,   // seq_index, cluster_size, weight_q15
  output logic                          m_axis_tlast
);
  import sir_pkg::*;

  typedef enum logic [2:0] {
    StLoad,
    StPair,
    StCmp,
    StDrain,
    StEval,
    StEmit
  } state_e;

  state_e state_q, state_d;

  logic [NumSeqsW-1:0] num_seqs_q;
  logic [NumColsW-1:0] num_cols_q;
  logic [ThrW-1:0]     thr_q;

  logic [AddrW-1:0] load_pos_q, load_pos_d;
  logic [SeqW-1:0]  i_q, i_d, j_q, j_d;
  logic [ColW-1:0]  k_q, k_d, same_q, same_d;
  logic [IdxW-1:0]  nbr_q, nbr_d;
  logic [AddrW-1:0] base_i_q, base_i_d, base_j_q, base_j_d;
  logic             rd_v_q, rd_v_d;

  logic               m_valid_q, m_valid_d;
  logic [OutIdxW-1:0] o_idx_q, o_idx_d;
  logic [SizeW-1:0]   o_size_q, o_size_d;
  logic [WeightW-1:0] o_wgt_q, o_wgt_d;
  logic               o_last_q, o_last_d;

  logic [SeqW-1:0]      seqs_eff;
  logic [ColW-1:0]      cols_eff;
  logic [AddrW:0]       total;
  logic [AddrW-1:0]     wpos;
  logic [AddrW:0]       pos_inc;
  logic                 in_acc;
  logic [ResW-1:0]      rd_a, rd_b;
  logic [AddrW-1:0]     raddr_a, raddr_b;
  logic [AddrW-1:0]     cols_step;
  logic                 is_last;

  always_comb begin
    if (num_seqs_q == '0) begin
      seqs_eff = SeqW'(1);
    end else if (num_seqs_q > NumSeqsW'(MaxSeqs)) begin
      seqs_eff = SeqW'(MaxSeqs);
    end else begin
      seqs_eff = SeqW'(num_seqs_q);
    end
    if (num_cols_q == '0) begin
      cols_eff = ColW'(1);
    end else if (num_cols_q > NumColsW'(MaxCols)) begin
      cols_eff = ColW'(MaxCols);
    end else begin
      cols_eff = ColW'(num_cols_q);
    end
  end

  assign total     = (AddrW+1)'(seqs_eff) * (AddrW+1)'(cols_eff);
  assign wpos      = ({1'b0, load_pos_q} >= total) ? '0 : load_pos_q;
  assign pos_inc   = {1'b0, wpos} + (AddrW+1)'(1);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign cols_step = AddrW'(cols_eff);
  assign raddr_a   = base_i_q + AddrW'(k_q);
  assign raddr_b   = base_j_q + AddrW'(k_q);
  assign is_last   = ((i_q + SeqW'(1)) == seqs_eff);

  sir_ram #(
    .Width(ResW),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (in_acc),
    .waddr_i  (wpos),
    .wdata_i  (s_axis_tdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  always_comb begin
    state_d    = state_q;
    load_pos_d = load_pos_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    same_d     = same_q;
    nbr_d      = nbr_q;
    base_i_d   = base_i_q;
    base_j_d   = base_j_q;
    rd_v_d     = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready;
    o_idx_d    = o_idx_q;
    o_size_d   = o_size_q;
    o_wgt_d    = o_wgt_q;
    o_last_d   = o_last_q;

    if (rd_v_q && (rd_a == rd_b)) begin
      same_d = same_q + ColW'(1);
    end

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (pos_inc == total) begin
            load_pos_d = '0;
            i_d        = '0;
            j_d        = '0;
            base_i_d   = '0;
            base_j_d   = '0;
            nbr_d      = '0;
            state_d    = StPair;
          end else begin
            load_pos_d = pos_inc[AddrW-1:0];
          end
        end
      end
      StPair: begin
        if (j_q == seqs_eff) begin
          state_d = StEmit;
        end else if (j_q == i_q) begin
          j_d      = j_q + SeqW'(1);
          base_j_d = base_j_q + cols_step;
        end else begin
          k_d     = '0;
          same_d  = '0;
          state_d = StCmp;
        end
      end
      StCmp: begin
        rd_v_d = 1'b1;
        k_d    = k_q + ColW'(1);
        if (k_q == cols_eff - ColW'(1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StEval;
      end
      StEval: begin
        if (CmpW'(same_q) > CmpW'(thr_q)) begin
          nbr_d = nbr_q + IdxW'(1);
        end
        j_d      = j_q + SeqW'(1);
        base_j_d = base_j_q + cols_step;
        state_d  = StPair;
      end
      StEmit: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          o_idx_d   = OutIdxW'(i_q);
          o_size_d  = SizeW'(nbr_q) + SizeW'(1);
          o_wgt_d   = WeightLut[nbr_q];
          o_last_d  = is_last;
          if (is_last) begin
            state_d = StLoad;
          end else begin
            i_d      = i_q + SeqW'(1);
            base_i_d = base_i_q + cols_step;
            j_d      = '0;
            base_j_d = '0;
            nbr_d    = '0;
            state_d  = StPair;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      num_seqs_q <= NumSeqsRst;
      num_cols_q <= NumColsRst;
      thr_q      <= ThreshRst;
      load_pos_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      same_q     <= '0;
      nbr_q      <= '0;
      base_i_q   <= '0;
      base_j_q   <= '0;
      rd_v_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      o_idx_q    <= '0;
      o_size_q   <= '0;
      o_wgt_q    <= '0;
      o_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegNumSeqs: num_seqs_q <= cfg_data_i[NumSeqsW-1:0];
          RegNumCols: num_cols_q <= cfg_data_i[NumColsW-1:0];
          RegThresh:  thr_q      <= cfg_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      same_q     <= same_d;
      nbr_q      <= nbr_d;
      base_i_q   <= base_i_d;
      base_j_q   <= base_j_d;
      rd_v_q     <= rd_v_d;
      m_valid_q  <= m_valid_d;
      o_idx_q    <= o_idx_d;
      o_size_q   <= o_size_d;
      o_wgt_q    <= o_wgt_d;
      o_last_q   <= o_last_d;
    end
  end

  assign s_axis_tready = (state_q == StLoad);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {(OutDataW - OutIdxW - SizeW - WeightW)'(0), o_wgt_q, o_size_q, o_idx_q};

endmodule

### hw/rtl/sir_checker.sv
module sir_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [sir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [sir_pkg::CfgW-1:0]      cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [sir_pkg::ResW-1:0]      s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sir_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);
  import sir_pkg::*;

  logic [SizeW-1:0]   size;
  logic [WeightW-1:0] wgt;

  assign size = m_axis_tdata[OutIdxW +: SizeW];
  assign wgt  = m_axis_tdata[OutIdxW + SizeW +: WeightW];

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (size != '0) && (size <= SizeW'(MaxSeqs)))
    else $error("cluster size out of range");

  a_self_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (size == SizeW'(1)) |-> (wgt == WeightLut[0]))
    else $error("weight of a lone sequence is not one");

  // input stays closed until the final weight of the run is out
  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open while results of the run remain");

endmodule

bind sequence_identity_reweight sir_checker u_sir_checker (.*);
